### src/bpa_pkg.sv
// Package of types, constants and states for the bitmap page allocator.
package bpa_pkg;

    localparam int NUM_WORDS  = 256;
    localparam int WORD_BITS  = 64;  // power of two
    localparam int PAGE_SH    = 12;  // 4 KiB pages
    localparam int IN_W       = 48;
    localparam int ADDR_W     = 26;

    localparam int WB_LOG     = $clog2(WORD_BITS);
    localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int PG_W       = WIDX_W + WB_LOG;
    localparam int TOTAL_PAGES = NUM_WORDS * WORD_BITS;
    localparam int PIDX_W     = IN_W + 1 - PAGE_SH;  // page index of a 49-bit byte address

    localparam int GRP_W      = 16;
    localparam int GRP_LOG    = $clog2(GRP_W);
    localparam int NUM_GRPS   = (NUM_WORDS + GRP_W - 1) / GRP_W;
    localparam int GIDX_W     = (NUM_GRPS > 1) ? $clog2(NUM_GRPS) : 1;

    typedef enum logic {
        REQ_ADD_RANGE = 1'b0,
        REQ_ALLOC     = 1'b1
    } t_req_type;

    typedef enum logic {
        STS_DONE    = 1'b0,
        STS_NO_PAGE = 1'b1
    } t_status;

    typedef struct packed {
        logic [0:0]      req_type;
        logic [IN_W-1:0] range_start;
        logic [IN_W-1:0] range_bytes;
    } t_bpa_req;

    typedef struct packed {
        logic [ADDR_W-1:0] page_addr;
        logic [0:0]        status;
    } t_bpa_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AL_GRP,
        ST_AL_WORD,
        ST_AL_BIT,
        ST_AR_CALC,
        ST_AR_CHK,
        ST_AR_RD,
        ST_AR_WR
    } t_state;

endpackage

### src/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/bitmap_page_allocator_top.sv
// Top level of the bitmap page allocator: sequencer, word marks and bitmap RAM.
//
// Usage: raise start with a request on i_req while busy is low; the request is
// taken at that edge and busy stays high until the result is issued. Every
// request gives exactly one result, shown on o_res for a single cycle with
// o_valid high; the receiver cannot stall it, so capture it on that cycle.
// An allocate steps through group pick, word pick with bitmap read, bit pick
// with write back and the result register, or ends at the group pick when no
// page is free. An add-range computes and checks the page range, then does one
// RAM read and one write back per bitmap word it touches, through the single
// RAM port pair, or ends at the check when the range covers no whole managed
// page. The next request may be taken in the cycle its predecessor's result is
// shown. No clearing pass is needed after reset: a word whose not-empty mark is
// clear reads as all pages used, whatever the RAM holds.
module bitmap_page_allocator_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  bpa_pkg::t_bpa_req i_req,
    output logic              busy,
    output logic              o_valid,
    output bpa_pkg::t_bpa_res o_res
);

    import bpa_pkg::*;

    localparam int PAD_W  = NUM_GRPS * GRP_W;
    localparam int WSUM_W = GIDX_W + GRP_LOG;
    localparam int FULL_W = PG_W + PAGE_SH;

    // State and registers
    t_state r_state, n_state;
    logic [NUM_WORDS-1:0] r_ne, n_ne;          // word holds a free page
    t_bpa_req             r_req, n_req;
    logic [GIDX_W-1:0]    r_grp, n_grp;
    logic [WIDX_W-1:0]    r_w, n_w;
    logic [PIDX_W-1:0]    r_first, n_first;
    logic [PIDX_W-1:0]    r_last, n_last;      // exclusive, clamped to capacity
    logic [WIDX_W-1:0]    r_lastw, n_lastw;
    logic [WB_LOG-1:0]    r_lo, n_lo;
    logic [WB_LOG-1:0]    r_hi, n_hi;          // last page in the last word
    logic                 r_first_word, n_first_word;
    logic                 r_out_vld, n_out_vld;
    t_bpa_res             r_out, n_out;

    // Combinational datapath
    logic [PAD_W-1:0]     ne_pad;
    logic [NUM_GRPS-1:0]  grp_any;
    logic                 grp_found;
    logic [GIDX_W-1:0]    grp_sel;
    logic [GRP_W-1:0]     grp_bits;
    logic [GRP_LOG-1:0]   sub_sel;
    logic [WSUM_W-1:0]    word_sum;
    logic [WIDX_W-1:0]    word_sel;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] cur_word;
    logic [WB_LOG-1:0]    bit_sel;
    logic [WORD_BITS-1:0] alloc_word;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] merged_word;
    logic [IN_W:0]        first_sum;
    logic [IN_W:0]        end_sum;
    logic [PIDX_W-1:0]    last_raw;
    logic [PIDX_W-1:0]    last_m1;
    logic                 range_ok;
    logic                 at_last_word;
    logic [PG_W-1:0]      page_idx;
    logic [FULL_W-1:0]    page_full;
    logic                 ram_we;
    logic [WIDX_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata;

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_w),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Group pick: highest group of words with any free page
    always_comb begin
        ne_pad = '0;
        ne_pad[NUM_WORDS-1:0] = r_ne;
        for (int g = 0; g < NUM_GRPS; g++) begin
            grp_any[g] = |ne_pad[g*GRP_W +: GRP_W];
        end
        grp_found = |grp_any;
        grp_sel = '0;
        for (int g = 0; g < NUM_GRPS; g++) begin
            if (grp_any[g]) begin
                grp_sel = GIDX_W'(g);
            end
        end
    end

    // Word pick: highest marked word inside the registered group
    always_comb begin
        grp_bits = ne_pad[r_grp*GRP_W +: GRP_W];
        sub_sel = '0;
        for (int s = 0; s < GRP_W; s++) begin
            if (grp_bits[s]) begin
                sub_sel = GRP_LOG'(s);
            end
        end
        word_sum = {r_grp, sub_sel};
        word_sel = WIDX_W'(word_sum);
    end

    // Bit pick: lowest free page of the word just read
    always_comb begin
        cur_word = r_ne[r_w] ? ram_rdata : '0;
        bit_sel = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (cur_word[b]) begin
                bit_sel = WB_LOG'(b);
            end
        end
        alloc_word = cur_word;
        alloc_word[bit_sel] = 1'b0;
        page_idx = {r_w, bit_sel};
        page_full = {page_idx, PAGE_SH'(0)};
    end

    // Add-range arithmetic: whole pages inside [start, start + bytes)
    always_comb begin
        first_sum = {1'b0, r_req.range_start} + (IN_W+1)'((1 << PAGE_SH) - 1);
        end_sum = {1'b0, r_req.range_start} + {1'b0, r_req.range_bytes};
        last_raw = end_sum[IN_W:PAGE_SH];
        range_ok = r_first < r_last;
        last_m1 = r_last - PIDX_W'(1);
        at_last_word = r_w == r_lastw;
        for (int b = 0; b < WORD_BITS; b++) begin
            range_mask[b] = (!r_first_word || WB_LOG'(b) >= r_lo)
                         && (!at_last_word || WB_LOG'(b) <= r_hi);
        end
        merged_word = cur_word | range_mask;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_req.req_type == REQ_ALLOC) ? ST_AL_GRP : ST_AR_CALC;
                end
            end
            ST_AL_GRP: begin
                n_state = grp_found ? ST_AL_WORD : ST_IDLE;
            end
            ST_AL_WORD: begin
                n_state = ST_AL_BIT;
            end
            ST_AL_BIT: begin
                n_state = ST_IDLE;
            end
            ST_AR_CALC: begin
                n_state = ST_AR_CHK;
            end
            ST_AR_CHK: begin
                n_state = range_ok ? ST_AR_RD : ST_IDLE;
            end
            ST_AR_RD: begin
                n_state = ST_AR_WR;
            end
            ST_AR_WR: begin
                n_state = at_last_word ? ST_IDLE : ST_AR_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs and register next values
    always_comb begin
        n_ne         = r_ne;
        n_req        = r_req;
        n_grp        = r_grp;
        n_w          = r_w;
        n_first      = r_first;
        n_last       = r_last;
        n_lastw      = r_lastw;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_first_word = r_first_word;
        n_out_vld    = 1'b0;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_raddr    = r_w;
        ram_wdata    = merged_word;
        case (r_state)
            ST_IDLE: begin
                n_req = i_req;
            end
            ST_AL_GRP: begin
                n_grp = grp_sel;
                if (!grp_found) begin
                    n_out_vld        = 1'b1;
                    n_out.page_addr  = '0;
                    n_out.status     = STS_NO_PAGE;
                end
            end
            ST_AL_WORD: begin
                // issue the bitmap read for the picked word
                ram_raddr = word_sel;
                n_w       = word_sel;
            end
            ST_AL_BIT: begin
                ram_we          = 1'b1;
                ram_wdata       = alloc_word;
                n_ne[r_w]       = |alloc_word;
                n_out_vld       = 1'b1;
                n_out.page_addr = ADDR_W'(page_full);
                n_out.status    = STS_DONE;
            end
            ST_AR_CALC: begin
                n_first = first_sum[IN_W:PAGE_SH];
                n_last  = (last_raw > PIDX_W'(TOTAL_PAGES)) ? PIDX_W'(TOTAL_PAGES)
                                                             : last_raw;
            end
            ST_AR_CHK: begin
                n_w          = WIDX_W'(r_first >> WB_LOG);
                n_lo         = r_first[WB_LOG-1:0];
                n_lastw      = WIDX_W'(last_m1 >> WB_LOG);
                n_hi         = last_m1[WB_LOG-1:0];
                n_first_word = 1'b1;
                if (!range_ok) begin
                    n_out_vld       = 1'b1;
                    n_out.page_addr = '0;
                    n_out.status    = STS_DONE;
                end
            end
            ST_AR_RD: begin
                ram_raddr = r_w;
            end
            ST_AR_WR: begin
                ram_we       = 1'b1;
                ram_wdata    = merged_word;
                n_ne[r_w]    = |merged_word;
                n_first_word = 1'b0;
                if (at_last_word) begin
                    n_out_vld       = 1'b1;
                    n_out.page_addr = '0;
                    n_out.status    = STS_DONE;
                end else begin
                    n_w = r_w + WIDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Control state clears on reset; payload and scratch registers hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ne      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ne      <= n_ne;
            r_out_vld <= n_out_vld;
        end
        r_req        <= n_req;
        r_grp        <= n_grp;
        r_w          <= n_w;
        r_first      <= n_first;
        r_last       <= n_last;
        r_lastw      <= n_lastw;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_first_word <= n_first_word;
        r_out        <= n_out;
    end

    assign busy    = r_state != ST_IDLE;
    assign o_valid = r_out_vld;
    assign o_res   = r_out;

endmodule
